// ===== src/utc_to_local_calendar_time_top_macros.svh =====
// ----------------------------------------------------------------------------
// UTC to local time converter: assertion macros
// Shared property wrappers; clk and rst are the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef UTC_TO_LOCAL_CALENDAR_TIME_TOP_MACROS_SVH
`define UTC_TO_LOCAL_CALENDAR_TIME_TOP_MACROS_SVH

// same-cycle implication
`define UTCL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTCL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/utcl_pkg.sv =====
// ----------------------------------------------------------------------------
// UTC to local time converter: package
// Field types, microcode encoding, program ROM and calendar helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utcl_pkg;

  localparam int YEAR_W = 12;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int TZ_W   = 11;

  // internal working widths
  localparam int YR_W   = 13;  // holds one year past the output range
  localparam int YMOD_W = 9;   // year modulo 400
  localparam int DAYS_W = 21;  // signed day count from 2000-01-01
  localparam int HH_W   = 7;   // signed hour carry
  localparam int MM_W   = 12;  // signed minute sum incl. offset

  localparam logic [YEAR_W-1:0] YEAR_BASE  = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_TOP   = 12'd4095;
  localparam logic [YR_W-1:0]   YR_BASE    = 13'd2000;
  localparam logic [YR_W-1:0]   YR_TOP     = 13'd4095;
  localparam logic [YR_W-1:0]   YR_CEIL    = 13'd4096;
  localparam logic [YR_W-1:0]   YR_ERA     = 13'd400;
  localparam logic [YMOD_W-1:0] YMOD_LAST  = 9'd399;
  localparam logic [MON_W-1:0]  MON_JAN    = 4'd1;
  localparam logic [MON_W-1:0]  MON_DEC    = 4'd12;
  localparam logic [SEC_W-1:0]  SEC_SIXTY  = 6'd60;

  localparam logic signed [DAYS_W-1:0] DAYS_ERA = 21'sd146097;  // days in 400 years
  localparam logic signed [DAYS_W-1:0] DAYS_ONE = 21'sd1;
  localparam logic signed [MM_W-1:0]   MM_HOUR  = 12'sd60;
  localparam logic signed [HH_W-1:0]   HH_DAY   = 7'sd24;
  localparam logic signed [HH_W-1:0]   HH_ONE   = 7'sd1;

  typedef struct packed {
    logic [YEAR_W-1:0] utc_year;
    logic [MON_W-1:0]  utc_month;
    logic [DAY_W-1:0]  utc_day;
    logic [HOUR_W-1:0] utc_hour;
    logic [MIN_W-1:0]  utc_minute;
    logic [SEC_W-1:0]  utc_second;
  } utc_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0] local_year;
    logic [MON_W-1:0]  local_month;
    logic [DAY_W-1:0]  local_day;
    logic [HOUR_W-1:0] local_hour;
    logic [MIN_W-1:0]  local_minute;
    logic [SEC_W-1:0]  local_second;
    logic              clamped;
  } local_item_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_FY400  = 4'd1;
  localparam step_t ST_FY1    = 4'd2;
  localparam step_t ST_FM     = 4'd3;
  localparam step_t ST_FD     = 4'd4;
  localparam step_t ST_MM_NEG = 4'd5;
  localparam step_t ST_MM_BIG = 4'd6;
  localparam step_t ST_HH_NEG = 4'd7;
  localparam step_t ST_HH_BIG = 4'd8;
  localparam step_t ST_REV    = 4'd9;
  localparam step_t ST_RY400  = 4'd10;
  localparam step_t ST_RY1    = 4'd11;
  localparam step_t ST_RM     = 4'd12;
  localparam step_t ST_OUT    = 4'd13;

  // NEXT: run op, advance. LOOP: run op and hold while cond, else advance.
  // WAIT: hold until cond, then run op and jump to target.
  typedef enum logic [1:0] {M_NEXT, M_LOOP, M_WAIT} mode_t;

  typedef enum logic [3:0] {
    C_TRUE, C_IN, C_OUT_FREE, C_FY400, C_FY1, C_FM, C_MM_NEG, C_MM_BIG,
    C_HH_NEG, C_HH_BIG, C_RY400, C_RY1, C_RM
  } cond_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_FY400, OP_FY1, OP_FM, OP_FD, OP_MM_UP, OP_MM_DN,
    OP_HH_UP, OP_HH_DN, OP_REV, OP_RY400, OP_RY1, OP_RM, OP_OUT
  } op_t;

  typedef struct packed {
    mode_t mode;
    cond_t cnd;
    op_t   op;
    step_t target;
  } ucode_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_req;
    logic out_free;
    logic fy400;
    logic fy1;
    logic fm;
    logic mm_neg;
    logic mm_big;
    logic hh_neg;
    logic hh_big;
    logic ry400;
    logic ry1;
    logic rm;
  } flags_t;

  typedef struct packed {
    step_t step;
    op_t   op;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:   w = '{M_WAIT, C_IN,       OP_LOAD,  ST_FY400};
      ST_FY400:  w = '{M_LOOP, C_FY400,    OP_FY400, ST_IDLE};
      ST_FY1:    w = '{M_LOOP, C_FY1,      OP_FY1,   ST_IDLE};
      ST_FM:     w = '{M_LOOP, C_FM,       OP_FM,    ST_IDLE};
      ST_FD:     w = '{M_NEXT, C_TRUE,     OP_FD,    ST_IDLE};
      ST_MM_NEG: w = '{M_LOOP, C_MM_NEG,   OP_MM_UP, ST_IDLE};
      ST_MM_BIG: w = '{M_LOOP, C_MM_BIG,   OP_MM_DN, ST_IDLE};
      ST_HH_NEG: w = '{M_LOOP, C_HH_NEG,   OP_HH_UP, ST_IDLE};
      ST_HH_BIG: w = '{M_LOOP, C_HH_BIG,   OP_HH_DN, ST_IDLE};
      ST_REV:    w = '{M_NEXT, C_TRUE,     OP_REV,   ST_IDLE};
      ST_RY400:  w = '{M_LOOP, C_RY400,    OP_RY400, ST_IDLE};
      ST_RY1:    w = '{M_LOOP, C_RY1,      OP_RY1,   ST_IDLE};
      ST_RM:     w = '{M_LOOP, C_RM,       OP_RM,    ST_IDLE};
      ST_OUT:    w = '{M_WAIT, C_OUT_FREE, OP_OUT,   ST_IDLE};
      default:   w = '{M_WAIT, C_TRUE,     OP_NOP,   ST_IDLE};
    endcase
    return w;
  endfunction

  // leap test from year mod 400
  function automatic logic leap_of(input logic [YMOD_W-1:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/utcl_seq.sv =====
// ----------------------------------------------------------------------------
// UTC to local time converter: microcode sequencer
// Step counter over the program ROM; issues one datapath op per cycle, a no-op while waiting or leaving a loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utcl_seq (
  input  logic            clk,
  input  logic            rst,
  input  utcl_pkg::flags_t flags,
  output utcl_pkg::ctrl_t  ctrl
);
  import utcl_pkg::*;

  step_t  pc;
  step_t  pc_next;
  ucode_t word;
  logic   hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    word = ucode_rom(pc);
    case (word.cnd)
      C_TRUE:     hit = 1'b1;
      C_IN:       hit = flags.in_req;
      C_OUT_FREE: hit = flags.out_free;
      C_FY400:    hit = flags.fy400;
      C_FY1:      hit = flags.fy1;
      C_FM:       hit = flags.fm;
      C_MM_NEG:   hit = flags.mm_neg;
      C_MM_BIG:   hit = flags.mm_big;
      C_HH_NEG:   hit = flags.hh_neg;
      C_HH_BIG:   hit = flags.hh_big;
      C_RY400:    hit = flags.ry400;
      C_RY1:      hit = flags.ry1;
      C_RM:       hit = flags.rm;
      default:    hit = 1'b0;
    endcase

    ctrl.step = pc;
    case (word.mode)
      M_NEXT: begin
        ctrl.op = word.op;
        pc_next = pc + 4'd1;
      end
      M_LOOP: begin
        ctrl.op = hit ? word.op : OP_NOP;
        pc_next = hit ? pc : pc + 4'd1;
      end
      M_WAIT: begin
        ctrl.op = hit ? word.op : OP_NOP;
        pc_next = hit ? word.target : pc;
      end
      default: begin
        ctrl.op = OP_NOP;
        pc_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/utc_to_local_calendar_time_top.sv =====
// ----------------------------------------------------------------------------
// UTC to local calendar time converter
// Shifts a UTC date and time by a signed minute offset, clamping at 2000 and saturating at 4095.
// ----------------------------------------------------------------------------
//  channel   signals                          payload
//  input     in_valid / in_stall              in_data   (utc_item_t)
//  output    out_valid / out_stall            out_data  (local_item_t)
//  config    cfg_wr_en                        cfg_wr_data (11-bit signed)
//
//  Sequence: a request holds the sequencer through the load, each program
//  step and the result write, plus loop steps for each 400-year block, year
//  and month, once building the day count and once taking it apart, and for
//  each hour and day of carry. The year loops dominate the run length. A new
//  request is taken once the step counter is back at idle; a finished result
//  sits in the output register meanwhile.
//  Reset clears the offset and the output valid. A stalled result holds the
//  sequencer at its final step.
`timescale 1ns / 1ps
`include "utc_to_local_calendar_time_top_macros.svh"

module utc_to_local_calendar_time_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  utcl_pkg::utc_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output utcl_pkg::local_item_t         out_data,
  input  logic                          cfg_wr_en,
  input  logic signed [utcl_pkg::TZ_W-1:0] cfg_wr_data
);
  import utcl_pkg::*;

  flags_t ctrl_flags;
  ctrl_t  ctrl;

  logic signed [TZ_W-1:0]   tz;
  logic [YR_W-1:0]          yr;
  logic [YMOD_W-1:0]        ymod;
  logic [YEAR_W-1:0]        tgt;
  logic [MON_W-1:0]         mlim;
  logic [MON_W-1:0]         mon;
  logic [DAY_W-1:0]         dayin;
  logic signed [DAYS_W-1:0] days;
  logic signed [HH_W-1:0]   hh;
  logic signed [MM_W-1:0]   mm;
  logic [SEC_W-1:0]         ss;

  logic                     leap;
  logic [8:0]               ylen;
  logic [DAY_W-1:0]         mdays;
  logic signed [DAYS_W-1:0] ylen_s;
  logic signed [DAYS_W-1:0] mdays_s;
  logic [YR_W-1:0]          yr_gap;
  logic [YMOD_W-1:0]        ymod_inc;
  logic                     sec_carry;

  utcl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (ctrl_flags),
    .ctrl  (ctrl)
  );

  assign in_stall = (ctrl.step != ST_IDLE);

  always_comb begin
    leap      = leap_of(ymod);
    ylen      = leap ? 9'd366 : 9'd365;
    mdays     = month_days(mon, leap);
    ylen_s    = $signed(DAYS_W'(ylen));
    mdays_s   = $signed(DAYS_W'(mdays));
    yr_gap    = {1'b0, tgt} - yr;
    ymod_inc  = (ymod == YMOD_LAST) ? '0 : ymod + 9'd1;
    sec_carry = (in_data.utc_second >= SEC_SIXTY);

    ctrl_flags.in_req   = in_valid;
    ctrl_flags.out_free = !out_valid || !out_stall;
    ctrl_flags.fy400    = (yr_gap >= YR_ERA);
    ctrl_flags.fy1      = (yr != {1'b0, tgt});
    ctrl_flags.fm       = (mon != mlim);
    ctrl_flags.mm_neg   = mm[MM_W-1];
    ctrl_flags.mm_big   = (mm >= MM_HOUR);
    ctrl_flags.hh_neg   = hh[HH_W-1];
    ctrl_flags.hh_big   = (hh >= HH_DAY);
    ctrl_flags.ry400    = (days >= DAYS_ERA);
    ctrl_flags.ry1      = (days >= ylen_s);
    ctrl_flags.rm       = (mon != MON_DEC) && (days >= mdays_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tz <= '0;
    end else if (cfg_wr_en) begin
      tz <= cfg_wr_data;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        yr    <= YR_BASE;
        ymod  <= '0;
        days  <= '0;
        mon   <= MON_JAN;
        tgt   <= (in_data.utc_year < YEAR_BASE) ? YEAR_BASE : in_data.utc_year;
        mlim  <= (in_data.utc_month == 4'd0) ? MON_JAN :
                 (in_data.utc_month > MON_DEC) ? MON_DEC : in_data.utc_month;
        dayin <= in_data.utc_day;
        hh    <= {2'b00, in_data.utc_hour};
        // minute + offset + second carry, normalised later
        mm    <= {6'd0, in_data.utc_minute} + {tz[TZ_W-1], tz} +
                 {11'd0, sec_carry};
        ss    <= sec_carry ? in_data.utc_second - SEC_SIXTY : in_data.utc_second;
      end
      OP_FY400: begin
        days <= days + DAYS_ERA;
        yr   <= yr + YR_ERA;
      end
      OP_FY1: begin
        days <= days + ylen_s;
        yr   <= yr + 13'd1;
        ymod <= ymod_inc;
      end
      OP_FM: begin
        days <= days + mdays_s;
        mon  <= mon + 4'd1;
      end
      OP_FD: begin
        days <= days + $signed(DAYS_W'(dayin)) - DAYS_ONE;
      end
      OP_MM_UP: begin
        mm <= mm + MM_HOUR;
        hh <= hh - HH_ONE;
      end
      OP_MM_DN: begin
        mm <= mm - MM_HOUR;
        hh <= hh + HH_ONE;
      end
      OP_HH_UP: begin
        hh   <= hh + HH_DAY;
        days <= days - DAYS_ONE;
      end
      OP_HH_DN: begin
        hh   <= hh - HH_DAY;
        days <= days + DAYS_ONE;
      end
      OP_REV: begin
        yr   <= YR_BASE;
        ymod <= '0;
        mon  <= MON_JAN;
      end
      OP_RY400: begin
        days <= days - DAYS_ERA;
        yr   <= yr + YR_ERA;
      end
      OP_RY1: begin
        days <= days - ylen_s;
        yr   <= yr + 13'd1;
        ymod <= ymod_inc;
      end
      OP_RM: begin
        days <= days - mdays_s;
        mon  <= mon + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT) begin
      if (days[DAYS_W-1]) begin
        // fell before 2000-01-01
        out_data.local_year   <= YEAR_BASE;
        out_data.local_month  <= MON_JAN;
        out_data.local_day    <= 5'd1;
        out_data.local_hour   <= '0;
        out_data.local_minute <= '0;
        out_data.local_second <= '0;
        out_data.clamped      <= 1'b1;
      end else if (yr > YR_TOP) begin
        out_data.local_year   <= YEAR_TOP;
        out_data.local_month  <= MON_DEC;
        out_data.local_day    <= 5'd31;
        out_data.local_hour   <= 5'd23;
        out_data.local_minute <= 6'd59;
        out_data.local_second <= 6'd59;
        out_data.clamped      <= 1'b0;
      end else begin
        out_data.local_year   <= yr[YEAR_W-1:0];
        out_data.local_month  <= mon;
        out_data.local_day    <= days[DAY_W-1:0] + 5'd1;
        out_data.local_hour   <= hh[HOUR_W-1:0];
        out_data.local_minute <= mm[MIN_W-1:0];
        out_data.local_second <= ss;
        out_data.clamped      <= 1'b0;
      end
    end
  end

  `UTCL_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, ctrl.step == ST_FY400,
                    "accepted request did not start the program")
  `UTCL_ASSERT_NOW(a_minute_norm, ctrl.step == ST_HH_NEG,
                   !mm[MM_W-1] && (mm < MM_HOUR), "minute carry not normalised")
  `UTCL_ASSERT_NOW(a_hour_norm, ctrl.step == ST_OUT,
                   !hh[HH_W-1] && (hh < HH_DAY), "hour carry not normalised")
  `UTCL_ASSERT_NOW(a_year_bound, ctrl.step != ST_IDLE, yr <= YR_CEIL,
                   "year counter ran past range")
  `UTCL_ASSERT_NOW(a_out_source, $rose(out_valid), $past(ctrl.step) == ST_OUT,
                   "result raised outside the final step")

endmodule

// ===== tb/utc_to_local_calendar_time_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC to local calendar time converter: testbench
// Directed calendar and offset corner cases, then randomised requests under
// three idling regimes and a long output hold-off. Results are checked field
// by field against a behavioural calendar predictor kept in this file.
// ----------------------------------------------------------------------------

module utc_to_local_calendar_time_top_tb;
  import utcl_pkg::*;

  localparam int  EPOCH_YEAR    = 2000;
  localparam int  LAST_YEAR     = 4095;
  localparam int  TZ_MIN_NORMAL = -720;
  localparam int  TZ_MAX_NORMAL = 840;
  localparam int  TZ_MIN_FIELD  = -1024;
  localparam int  TZ_MAX_FIELD  = 1023;
  localparam int  CHUNK_ITEMS   = 52;
  localparam int  SETTLE_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 2000000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  utc_item_t                in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  local_item_t              out_data;
  logic                     cfg_wr_en = 1'b0;
  logic signed [TZ_W-1:0]   cfg_wr_data = '0;

  logic signed [TZ_W-1:0]   tz_offset = '0;   // offset currently held by the block
  local_item_t              expected_local[$];
  int                       errors = 0;
  int                       send_idle_pct = 0;
  int                       stall_pct = 0;
  int                       hold_left = 0;
  event                     hold_start;
  longint                   cycle_count = 0;

  utc_to_local_calendar_time_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic bit is_leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint leaps_through(input longint y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic longint month_length(input longint y, input longint m);
    case (m)
      2:       return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic local_item_t local_time_of(input utc_item_t r,
                                                input logic signed [TZ_W-1:0] tz);
    longint      yr;
    longint      mon;
    longint      days;
    longint      secs;
    longint      m;
    local_item_t o;
    o   = '0;
    yr  = longint'(r.utc_year);
    mon = longint'(r.utc_month);
    if (yr < EPOCH_YEAR) yr = EPOCH_YEAR;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    days = 365 * (yr - EPOCH_YEAR) + leaps_through(yr - 1) - leaps_through(EPOCH_YEAR - 1);
    for (m = 1; m < mon; m++) days += month_length(yr, m);
    days += longint'(r.utc_day) - 1;
    secs = ((days * 24 + longint'(r.utc_hour)) * 60 + longint'(r.utc_minute)) * 60
           + longint'(r.utc_second) + longint'(tz) * 60;
    if (secs < 0) begin
      o.local_year  = YEAR_BASE;
      o.local_month = MON_JAN;
      o.local_day   = DAY_W'(1);
      o.clamped     = 1'b1;
      return o;
    end
    o.local_second = SEC_W'(secs % 60);
    secs = secs / 60;
    o.local_minute = MIN_W'(secs % 60);
    secs = secs / 60;
    o.local_hour   = HOUR_W'(secs % 24);
    days = secs / 24;
    yr = EPOCH_YEAR;
    while (days >= (is_leap_year(yr) ? 366 : 365)) begin
      days -= is_leap_year(yr) ? 366 : 365;
      yr++;
    end
    if (yr > LAST_YEAR) begin
      // saturates at the last representable second, not flagged
      o.local_year   = YEAR_TOP;
      o.local_month  = MON_DEC;
      o.local_day    = DAY_W'(31);
      o.local_hour   = HOUR_W'(23);
      o.local_minute = MIN_W'(59);
      o.local_second = SEC_W'(59);
      return o;
    end
    m = 1;
    while (m < 12 && days >= month_length(yr, m)) begin
      days -= month_length(yr, m);
      m++;
    end
    o.local_year  = YEAR_W'(yr);
    o.local_month = MON_W'(m);
    o.local_day   = DAY_W'(days + 1);
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic utc_item_t make_utc(input int y, input int mo, input int d,
                                         input int h, input int mi, input int s);
    utc_item_t r;
    r.utc_year   = YEAR_W'(y);
    r.utc_month  = MON_W'(mo);
    r.utc_day    = DAY_W'(d);
    r.utc_hour   = HOUR_W'(h);
    r.utc_minute = MIN_W'(mi);
    r.utc_second = SEC_W'(s);
    return r;
  endfunction

  function automatic utc_item_t random_utc_item();
    int          kind;
    int          y;
    int          mo;
    int          dim;
    logic [63:0] raw;
    utc_item_t   r;
    kind = $urandom_range(99);
    y    = $urandom_range(2099, EPOCH_YEAR);
    mo   = $urandom_range(12, 1);
    dim  = int'(month_length(longint'(y), longint'(mo)));
    if (kind < 70) begin
      r = make_utc(y, mo, $urandom_range(dim, 1), $urandom_range(23), $urandom_range(59),
                   $urandom_range(59));
    end else if (kind < 82) begin
      // close to the epoch, where negative offsets clamp
      r = make_utc(EPOCH_YEAR, 1, $urandom_range(2), $urandom_range(23), $urandom_range(59),
                   $urandom_range(59));
    end else if (kind < 90) begin
      case ($urandom_range(2))
        0:       r = make_utc(y, mo, dim, 23, 59, 59);
        1:       r = make_utc(y, mo, 0, 0, 0, 0);
        default: r = make_utc(y, mo, 31, $urandom_range(23), 59, $urandom_range(59));
      endcase
    end else begin
      raw = {$urandom, $urandom};
      r   = raw[$bits(utc_item_t)-1:0];
    end
    return r;
  endfunction

  // drive one request and hold it until the block takes it
  task automatic offer_request(input utc_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_local.push_back(local_time_of(r, tz_offset));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_local.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_tz_offset(input int minutes);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= TZ_W'(minutes);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tz_offset    = TZ_W'(minutes);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_local(input local_item_t got);
    local_item_t want;
    if (expected_local.size() == 0) begin
      $error("result with no request outstanding: %p", got);
      errors++;
      return;
    end
    want = expected_local.pop_front();
    compare_field("local_year",   int'(want.local_year),   int'(got.local_year));
    compare_field("local_month",  int'(want.local_month),  int'(got.local_month));
    compare_field("local_day",    int'(want.local_day),    int'(got.local_day));
    compare_field("local_hour",   int'(want.local_hour),   int'(got.local_hour));
    compare_field("local_minute", int'(want.local_minute), int'(got.local_minute));
    compare_field("local_second", int'(want.local_second), int'(got.local_second));
    compare_field("clamped",      int'(want.clamped),      int'(got.clamped));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_local(out_data);
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // receiver hold-off, counted here once the pressure test starts it
  always begin
    @(hold_start);
    hold_left <= 1500;
    @(posedge clk);
    while (hold_left != 0) begin
      hold_left <= hold_left - 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_calendar_edges();
    // offset still at its reset value
    offer_request(make_utc(EPOCH_YEAR, 1, 1, 0, 0, 0));
    offer_request(make_utc(2099, 12, 31, 23, 59, 59));
    offer_request(make_utc(2000, 2, 29, 12, 0, 0));      // leap by the 400 rule
    offer_request(make_utc(2100, 2, 29, 0, 0, 0));       // century, not leap
    offer_request(make_utc(2024, 4, 31, 8, 30, 0));      // rolls into May
    offer_request(make_utc(0, 6, 15, 1, 2, 3));          // year below epoch
    offer_request(make_utc(1999, 12, 31, 23, 59, 59));
    offer_request(make_utc(2010, 0, 10, 10, 10, 10));    // month zero
    offer_request(make_utc(2010, 15, 10, 10, 10, 10));   // month past December
    offer_request(make_utc(2001, 3, 0, 0, 0, 0));        // day zero
    offer_request(make_utc(EPOCH_YEAR, 1, 0, 23, 59, 59)); // day zero before epoch
    offer_request(make_utc(2050, 12, 31, 31, 63, 63));   // hour/min/sec overflow
    offer_request(make_utc(LAST_YEAR, 15, 31, 31, 63, 63));
  endtask

  task automatic test_offset_extremes();
    set_tz_offset(TZ_MIN_NORMAL);
    offer_request(make_utc(EPOCH_YEAR, 1, 1, 11, 59, 59));   // clamps
    offer_request(make_utc(EPOCH_YEAR, 1, 1, 12, 0, 0));     // lands on the epoch
    set_tz_offset(TZ_MAX_NORMAL);
    offer_request(make_utc(2099, 12, 31, 10, 0, 0));         // into 2100
    offer_request(make_utc(LAST_YEAR, 12, 31, 10, 0, 0));    // saturates
    set_tz_offset(TZ_MIN_FIELD);
    offer_request(make_utc(EPOCH_YEAR, 1, 1, 17, 4, 0));
    offer_request(make_utc(2016, 3, 1, 0, 0, 0));            // back into Feb 29
    set_tz_offset(TZ_MAX_FIELD);
    offer_request(make_utc(LAST_YEAR, 12, 31, 7, 0, 0));
    offer_request(make_utc(2000, 12, 31, 20, 0, 0));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_p);
    int tz;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(99) < 20) tz = $urandom_range(TZ_MAX_FIELD - TZ_MIN_FIELD) + TZ_MIN_FIELD;
      else tz = $urandom_range(TZ_MAX_NORMAL - TZ_MIN_NORMAL) + TZ_MIN_NORMAL;
      set_tz_offset(tz);
      for (int i = 0; i < CHUNK_ITEMS; i++) offer_request(random_utc_item());
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    stall_pct     = 0;
    drain();
    -> hold_start;
    for (int i = 0; i < 8; i++) offer_request(random_utc_item());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_calendar_edges();
    test_offset_extremes();
    test_random_traffic(30, 53);
    test_random_traffic(53, 30);
    test_random_traffic(0, 0);
    test_output_hold_off();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/utcl_pkg.sv
src/utcl_seq.sv
src/utc_to_local_calendar_time_top.sv
tb/utc_to_local_calendar_time_top_tb.sv
